[sv/pdsn_pkg.sv]
package pdsn_pkg;

    localparam int unsigned PDSN_PATH_BYTES = 1024;

    localparam int unsigned LEN_W  = 11;
    localparam int unsigned BYTE_W = 8;

    localparam logic [BYTE_W-1:0] SLASH_CHAR = 8'h2F;
    localparam logic [BYTE_W-1:0] DOT_CHAR   = 8'h2E;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    localparam logic [2:0] STAT_ACCEPT = 3'd0;
    localparam logic [2:0] STAT_DONE   = 3'd1;
    localparam logic [2:0] STAT_ROOT   = 3'd2;
    localparam logic [2:0] STAT_LEAD   = 3'd3;
    localparam logic [2:0] STAT_OVER   = 3'd4;
    localparam logic [2:0] STAT_READ   = 3'd5;

    localparam logic [1:0] MODE_PLAIN  = 2'd0;
    localparam logic [1:0] MODE_SLASH  = 2'd1;
    localparam logic [1:0] MODE_DOT    = 2'd2;
    localparam logic [1:0] MODE_DOTDOT = 2'd3;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_ROOT,
        ERR_LEAD,
        ERR_OVER
    } t_err;

    function automatic logic [2:0] err_status(input t_err err);
        logic [2:0] s;
        unique case (err)
            ERR_ROOT: s = STAT_ROOT;
            ERR_LEAD: s = STAT_LEAD;
            ERR_OVER: s = STAT_OVER;
            default:  s = STAT_DONE;
        endcase
        return s;
    endfunction

endpackage

[sv/pdsn_ram.sv]
module pdsn_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/path_dot_segment_normalizer.sv]
// a path byte, end word or unused kind that needs no scan gives its result in the cycle
// after acceptance; a read word waits in ST_READ for the registered buffer byte
// a "/../" byte or an end word after a trailing "/.." scans the buffer backward one
// position per cycle, busy meanwhile
// throughput: one word per cycle for plain bytes, set by the single buffer port
// reset: synchronous active low, clears counters and flags; buffer contents are not cleared
module path_dot_segment_normalizer
    import pdsn_pkg::*;
#(
    parameter int unsigned PATH_BYTES = PDSN_PATH_BYTES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_kind,
    input  logic [7:0]       i_char_byte,
    input  logic [9:0]       i_read_index,
    output logic             o_strobe,
    output logic [2:0]       o_status,
    output logic [LEN_W-1:0] o_path_length,
    output logic [7:0]       o_data_byte
);

    localparam int unsigned AW = $clog2(PATH_BYTES);
    localparam int unsigned CW = $clog2(PATH_BYTES + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_wcount, n_wcount;
    logic [1:0]         r_mode, n_mode;
    logic               r_first, n_first;
    t_err               r_err, n_err;
    logic [CW-1:0]      r_final, n_final;
    logic [AW-1:0]      r_scan, n_scan;
    logic               r_fin, n_fin;
    logic               r_rd_hit, n_rd_hit;
    logic               r_strobe, n_strobe;
    logic [2:0]         r_status, n_status;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [7:0]         r_data, n_data;

    logic               mem_we;
    logic [AW-1:0]      mem_addr;
    logic [7:0]         mem_rdata;

    logic               is_slash;
    logic               is_dot;
    logic [1:0]         next_mode;
    logic [CW-1:0]      w_less5;
    logic [CW-1:0]      w_less4;
    logic [CW-1:0]      found_len;
    t_err               fin_err;
    t_err               end_err;
    logic [CW-1:0]      end_len;

    pdsn_ram #(
        .WIDTH (8),
        .DEPTH (PATH_BYTES)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (i_char_byte),
        .o_rdata (mem_rdata)
    );

    assign busy = (r_state != ST_IDLE);

    assign is_slash = (i_char_byte == SLASH_CHAR);
    assign is_dot   = (i_char_byte == DOT_CHAR);

    always_comb begin
        unique case (r_mode)
            MODE_PLAIN: next_mode = is_slash ? MODE_SLASH : MODE_PLAIN;
            MODE_SLASH: next_mode = is_dot ? MODE_DOT : MODE_PLAIN;
            MODE_DOT:   next_mode = is_dot ? MODE_DOTDOT : MODE_PLAIN;
            default:    next_mode = MODE_PLAIN;
        endcase
    end

    // backward scan starts at or below the last byte of x in the "/x/.." tail
    assign w_less5 = (r_wcount >= CW'(5)) ? r_wcount - CW'(5) : '0;
    assign w_less4 = (r_wcount >= CW'(4)) ? r_wcount - CW'(4) : '0;
    assign found_len = CW'(r_scan) + CW'(1);

    // end word outcome when no scan is needed
    assign fin_err = (r_first && r_err == ERR_NONE) ? ERR_LEAD : r_err;
    always_comb begin
        end_err = fin_err;
        end_len = r_wcount;
        if (fin_err == ERR_NONE && r_mode == MODE_DOTDOT) begin
            end_err = ERR_ROOT;
        end
        if (end_err != ERR_NONE) begin
            end_len = '0;
        end else if (r_mode == MODE_DOT) begin
            end_len = r_wcount - CW'(1);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_wcount = r_wcount;
        n_mode   = r_mode;
        n_first  = r_first;
        n_err    = r_err;
        n_final  = r_final;
        n_scan   = r_scan;
        n_fin    = r_fin;
        n_rd_hit = r_rd_hit;
        n_strobe = 1'b0;
        n_status = r_status;
        n_len    = r_len;
        n_data   = r_data;
        mem_we   = 1'b0;
        mem_addr = AW'(r_wcount);

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    unique case (i_kind)
                        KIND_BYTE: begin
                            n_strobe = 1'b1;
                            n_status = STAT_ACCEPT;
                            n_data   = '0;
                            n_first  = 1'b0;
                            if (r_first && !is_slash) begin
                                n_err = ERR_LEAD;
                            end else if (r_err != ERR_NONE) begin
                                n_err = r_err;
                            end else if (is_slash && r_mode == MODE_SLASH) begin
                                n_mode = MODE_SLASH;
                            end else if (is_slash && r_mode == MODE_DOT) begin
                                n_wcount = r_wcount - CW'(1);
                                n_mode   = MODE_SLASH;
                            end else if (is_slash && r_mode == MODE_DOTDOT) begin
                                if (r_wcount == CW'(3)) begin
                                    n_err = ERR_ROOT;
                                end else begin
                                    n_strobe = 1'b0;
                                    n_state  = ST_SCAN;
                                    n_fin    = 1'b0;
                                    n_scan   = AW'(w_less5);
                                    mem_addr = AW'(w_less5);
                                end
                            end else if (r_wcount >= CW'(PATH_BYTES)) begin
                                n_err = ERR_OVER;
                            end else begin
                                mem_we   = 1'b1;
                                mem_addr = AW'(r_wcount);
                                n_wcount = r_wcount + CW'(1);
                                n_mode   = next_mode;
                            end
                            n_len = LEN_W'(n_wcount);
                        end
                        KIND_END: begin
                            if (fin_err == ERR_NONE && r_mode == MODE_DOTDOT
                                    && r_wcount != CW'(3)) begin
                                n_state  = ST_SCAN;
                                n_fin    = 1'b1;
                                n_scan   = AW'(w_less4);
                                mem_addr = AW'(w_less4);
                            end else begin
                                n_strobe = 1'b1;
                                n_status = err_status(end_err);
                                n_final  = end_len;
                                n_len    = LEN_W'(end_len);
                                n_data   = '0;
                                n_wcount = '0;
                                n_mode   = MODE_PLAIN;
                                n_first  = 1'b1;
                                n_err    = ERR_NONE;
                            end
                        end
                        KIND_READ: begin
                            n_state  = ST_READ;
                            mem_addr = AW'(i_read_index);
                            n_rd_hit = ({{CW{1'b0}}, i_read_index} < {10'd0, r_final});
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_status = STAT_ACCEPT;
                            n_len    = LEN_W'(r_wcount);
                            n_data   = '0;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_state  = ST_IDLE;
                n_strobe = 1'b1;
                n_status = STAT_READ;
                n_len    = LEN_W'(r_final);
                n_data   = r_rd_hit ? mem_rdata : '0;
            end
            ST_SCAN: begin
                // mem_rdata holds the byte at r_scan
                if (r_scan == '0 || mem_rdata == SLASH_CHAR) begin
                    n_state  = ST_IDLE;
                    n_strobe = 1'b1;
                    n_len    = LEN_W'(found_len);
                    n_data   = '0;
                    if (r_fin) begin
                        n_status = STAT_DONE;
                        n_final  = found_len;
                        n_wcount = '0;
                        n_mode   = MODE_PLAIN;
                        n_first  = 1'b1;
                        n_err    = ERR_NONE;
                    end else begin
                        n_status = STAT_ACCEPT;
                        n_wcount = found_len;
                        n_mode   = MODE_SLASH;
                    end
                end else begin
                    n_scan   = r_scan - AW'(1);
                    mem_addr = r_scan - AW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_wcount <= '0;
            r_mode   <= MODE_PLAIN;
            r_first  <= 1'b1;
            r_err    <= ERR_NONE;
            r_final  <= '0;
            r_fin    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wcount <= n_wcount;
            r_mode   <= n_mode;
            r_first  <= n_first;
            r_err    <= n_err;
            r_final  <= n_final;
            r_fin    <= n_fin;
            r_strobe <= n_strobe;
        end
        r_scan   <= n_scan;
        r_rd_hit <= n_rd_hit;
        r_status <= n_status;
        r_len    <= n_len;
        r_data   <= n_data;
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_path_length = r_len;
    assign o_data_byte   = r_data;

`ifndef SYNTHESIS
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result word while busy");

    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == KIND_READ) |=> busy ##1 (o_strobe && !busy))
        else $error("read word not answered two cycles after acceptance");

    a_wcount_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wcount <= CW'(PATH_BYTES))
        else $error("write count beyond buffer size");

    a_final_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_final <= CW'(PATH_BYTES))
        else $error("final length beyond buffer size");

    a_scan_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (CW'(r_scan) < r_wcount))
        else $error("backward scan outside written bytes");
`endif

endmodule

[sim/pdsn_checker.sv]
`timescale 1ns / 100ps

module pdsn_checker
    import pdsn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  logic [1:0]       i_kind,
    input  logic [7:0]       i_char_byte,
    input  logic [9:0]       i_read_index,
    input  logic             i_strobe,
    input  logic [2:0]       i_status,
    input  logic [LEN_W-1:0] i_path_length,
    input  logic [7:0]       i_data_byte,
    output int               o_pending,
    output int               o_errors
);

    typedef struct packed {
        logic [2:0]       status;
        logic [LEN_W-1:0] length;
        logic [7:0]       data;
    } t_result;

    // shadow of the normalizer state
    logic [7:0]  norm_buf [PDSN_PATH_BYTES];
    int unsigned wr_len;
    logic [1:0]  seg_state;
    bit          at_first;
    t_err        fault;
    int unsigned done_len;

    t_result expected_q[$];
    int      mismatch_cnt;

    assign o_errors = mismatch_cnt;

    // nearest slash at or below the given position, stopping at position 0
    function automatic int unsigned prev_slash(input int unsigned from);
        int unsigned i;
        i = (from >= PDSN_PATH_BYTES) ? PDSN_PATH_BYTES - 1 : from;
        while (i > 0 && norm_buf[i] != SLASH_CHAR)
            i--;
        return i;
    endfunction

    function automatic t_result normalize_word(input logic [1:0] kind, input logic [7:0] c,
                                               input logic [9:0] idx);
        t_result     res;
        int unsigned w;
        int unsigned len;
        res.status = STAT_ACCEPT;
        res.data   = 8'h00;
        w          = wr_len;
        case (kind)
            KIND_BYTE: begin
                if (at_first) begin
                    at_first = 1'b0;
                    if (c != SLASH_CHAR)
                        fault = ERR_LEAD;
                end
                if (fault == ERR_NONE) begin
                    if (c == SLASH_CHAR && seg_state == MODE_DOT) begin
                        wr_len    = w - 1;
                        seg_state = MODE_SLASH;
                    end else if (c == SLASH_CHAR && seg_state == MODE_DOTDOT) begin
                        if (w == 3) begin
                            fault = ERR_ROOT;
                        end else begin
                            wr_len    = prev_slash(w >= 5 ? w - 5 : 0) + 1;
                            seg_state = MODE_SLASH;
                        end
                    end else if (!(c == SLASH_CHAR && seg_state == MODE_SLASH)) begin
                        if (w >= PDSN_PATH_BYTES) begin
                            fault = ERR_OVER;
                        end else begin
                            norm_buf[w] = c;
                            wr_len      = w + 1;
                            case (seg_state)
                                MODE_PLAIN: begin
                                    if (c == SLASH_CHAR)
                                        seg_state = MODE_SLASH;
                                end
                                MODE_SLASH, MODE_DOT: begin
                                    if (c != DOT_CHAR)
                                        seg_state = MODE_PLAIN;
                                    else if (seg_state == MODE_SLASH)
                                        seg_state = MODE_DOT;
                                    else
                                        seg_state = MODE_DOTDOT;
                                end
                                default: seg_state = MODE_PLAIN;
                            endcase
                        end
                    end
                end
                res.length = LEN_W'(wr_len);
            end
            KIND_END: begin
                res.status = STAT_DONE;
                len        = w;
                if (at_first && fault == ERR_NONE)
                    fault = ERR_LEAD;
                if (fault == ERR_NONE) begin
                    if (seg_state == MODE_DOT) begin
                        len = w - 1;
                    end else if (seg_state == MODE_DOTDOT) begin
                        if (w == 3)
                            fault = ERR_ROOT;
                        else
                            len = prev_slash(w >= 4 ? w - 4 : 0) + 1;
                    end
                end
                if (fault != ERR_NONE) begin
                    case (fault)
                        ERR_ROOT: res.status = STAT_ROOT;
                        ERR_LEAD: res.status = STAT_LEAD;
                        default:  res.status = STAT_OVER;
                    endcase
                    len = 0;
                end
                done_len   = len;
                wr_len     = 0;
                seg_state  = MODE_PLAIN;
                at_first   = 1'b1;
                fault      = ERR_NONE;
                res.length = LEN_W'(len);
            end
            KIND_READ: begin
                res.status = STAT_READ;
                res.length = LEN_W'(done_len);
                if (idx < done_len)
                    res.data = norm_buf[idx];
            end
            default: res.length = LEN_W'(wr_len);
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result exp_res;
        if (!i_rst_n) begin
            wr_len    = 0;
            seg_state = MODE_PLAIN;
            at_first  = 1'b1;
            fault     = ERR_NONE;
            done_len  = 0;
            expected_q.delete();
            o_pending <= 0;
        end else begin
            if (i_strobe) begin
                if (expected_q.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: unexpected result status %0d length %0d data %0h",
                             $time, i_status, i_path_length, i_data_byte);
                end else begin
                    exp_res = expected_q.pop_front();
                    if (i_status !== exp_res.status || i_path_length !== exp_res.length ||
                        i_data_byte !== exp_res.data) begin
                        mismatch_cnt++;
                        if (i_status !== exp_res.status)
                            $display("%0t: status expected %0d actual %0d",
                                     $time, exp_res.status, i_status);
                        if (i_path_length !== exp_res.length)
                            $display("%0t: path_length expected %0d actual %0d",
                                     $time, exp_res.length, i_path_length);
                        if (i_data_byte !== exp_res.data)
                            $display("%0t: data_byte expected %0h actual %0h",
                                     $time, exp_res.data, i_data_byte);
                    end
                end
            end
            if (i_start && !i_busy)
                expected_q.push_back(normalize_word(i_kind, i_char_byte, i_read_index));
            o_pending <= expected_q.size();
        end
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;
    import pdsn_pkg::*;

    localparam logic [1:0] KIND_SPARE = 2'd3;

    typedef logic [7:0] t_bytes [$];

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             start        = 1'b0;
    logic             busy;
    logic [1:0]       i_kind       = KIND_BYTE;
    logic [7:0]       i_char_byte  = 8'h00;
    logic [9:0]       i_read_index = 10'd0;
    logic             o_strobe;
    logic [2:0]       o_status;
    logic [LEN_W-1:0] o_path_length;
    logic [7:0]       o_data_byte;

    int pending;
    int mismatches;
    int idle_pct = 0;
    int sent_words = 0;
    int kind_count [4];

    always #5 i_clk = ~i_clk;

    path_dot_segment_normalizer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_char_byte   (i_char_byte),
        .i_read_index  (i_read_index),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_path_length (o_path_length),
        .o_data_byte   (o_data_byte)
    );

    pdsn_checker u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_kind        (i_kind),
        .i_char_byte   (i_char_byte),
        .i_read_index  (i_read_index),
        .i_strobe      (o_strobe),
        .i_status      (o_status),
        .i_path_length (o_path_length),
        .i_data_byte   (o_data_byte),
        .o_pending     (pending),
        .o_errors      (mismatches)
    );

    // offer one word and hold it until the block takes it, then maybe go quiet
    task automatic drive_word(input logic [1:0] kind, input logic [7:0] ch,
                              input logic [9:0] idx);
        start        <= 1'b1;
        i_kind       <= kind;
        i_char_byte  <= ch;
        i_read_index <= idx;
        do @(posedge i_clk); while (busy);
        sent_words++;
        kind_count[kind]++;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            drive_word(KIND_BYTE, s[i], 10'($urandom));
    endtask

    // hold off until every outstanding result is back
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic run_phase(input int pct, input int words);
        t_bytes     path;
        int         target;
        int         depth;
        int         nseg;
        int         nlen;
        int         r;
        logic [7:0] ch;
        logic [9:0] idx;
        idle_pct = pct;
        target   = sent_words + words;
        while (sent_words < target) begin
            path.delete();
            if ($urandom_range(99) < 6) begin
                // noise: short run of arbitrary bytes, often without a leading slash
                nlen = $urandom_range(0, 6);
                repeat (nlen) path.push_back(8'($urandom));
            end else begin
                path.push_back(SLASH_CHAR);
                depth = 0;
                nseg  = $urandom_range(0, 7);
                for (int s = 0; s < nseg; s++) begin
                    r = $urandom_range(99);
                    if (r < 45 || (r >= 60 && r < 78 && depth == 0 &&
                                   $urandom_range(4) != 0)) begin
                        nlen = ($urandom_range(19) == 0) ? $urandom_range(20, 120)
                                                         : $urandom_range(1, 4);
                        repeat (nlen) begin
                            case ($urandom_range(9))
                                0:       ch = 8'($urandom);
                                1:       ch = DOT_CHAR;
                                default: ch = 8'h61 + 8'($urandom_range(25));
                            endcase
                            path.push_back(ch);
                        end
                        depth++;
                    end else if (r < 60) begin
                        path.push_back(DOT_CHAR);
                    end else if (r < 78) begin
                        path.push_back(DOT_CHAR);
                        path.push_back(DOT_CHAR);
                        if (depth > 0)
                            depth--;
                    end else if (r >= 88) begin
                        // dotted names that are not dot segments
                        path.push_back(DOT_CHAR);
                        path.push_back(8'h61 + 8'($urandom_range(25)));
                        depth++;
                    end
                    if (s < nseg - 1 || $urandom_range(1) == 1)
                        path.push_back(SLASH_CHAR);
                end
            end
            foreach (path[i]) begin
                if ($urandom_range(99) < 4)
                    drive_word(KIND_READ, 8'($urandom), 10'($urandom));
                if ($urandom_range(99) < 1)
                    drive_word(KIND_SPARE, 8'($urandom), 10'($urandom));
                drive_word(KIND_BYTE, path[i], 10'($urandom));
            end
            // now and then leave the path open so the next one runs on into it
            if ($urandom_range(99) < 96)
                drive_word(KIND_END, 8'($urandom), 10'($urandom));
            repeat ($urandom_range(0, 3)) begin
                if ($urandom_range(9) < 7)
                    idx = 10'($urandom_range(0, path.size() + 1 > 1023 ? 1023
                                                                      : path.size() + 1));
                else
                    idx = 10'($urandom);
                drive_word(KIND_READ, 8'($urandom), idx);
            end
        end
        drain();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: spare kind, read and end on an empty block, missing leading slash,
        // climbing above the root, then collapse, dot removal and backing up
        drive_word(KIND_SPARE, 8'hA5, 10'h3FF);
        drive_word(KIND_READ, 8'h00, 10'd0);
        drive_word(KIND_END, 8'h00, 10'd0);
        send_text("x");
        drive_word(KIND_END, 8'hFF, 10'd0);
        send_text("/../x");
        drive_word(KIND_END, 8'h00, 10'd0);
        drive_word(KIND_BYTE, SLASH_CHAR, 10'd0);
        drive_word(KIND_BYTE, 8'h00, 10'd0);
        send_text("//./");
        drive_word(KIND_BYTE, 8'hFF, 10'h3FF);
        send_text("/../.");
        drive_word(KIND_END, 8'h00, 10'd0);
        drive_word(KIND_READ, 8'h00, 10'd1);
        drive_word(KIND_READ, 8'h00, 10'h3FF);
        drain();

        run_phase(36, 65);
        run_phase(78, 65);
        run_phase(0, 65);

        // fill the buffer through a dot segment, collapse and double a slash at full,
        // take the last free byte, then one byte too many
        drive_word(KIND_BYTE, SLASH_CHAR, 10'($urandom));
        repeat (PDSN_PATH_BYTES - 3)
            drive_word(KIND_BYTE, 8'h61 + 8'($urandom_range(25)), 10'($urandom));
        send_text("/.");
        send_text("//");
        drive_word(KIND_BYTE, 8'h61 + 8'($urandom_range(25)), 10'($urandom));
        drive_word(KIND_BYTE, 8'h61 + 8'($urandom_range(25)), 10'($urandom));
        drive_word(KIND_END, 8'($urandom), 10'($urandom));
        drive_word(KIND_READ, 8'($urandom), 10'h3FF);
        drive_word(KIND_READ, 8'($urandom), 10'($urandom));

        drain();
        repeat (20) @(posedge i_clk);

        $display("covered %0d words: %0d path bytes, %0d ends, %0d reads, %0d spare kind",
                 sent_words, kind_count[KIND_BYTE], kind_count[KIND_END],
                 kind_count[KIND_READ], kind_count[KIND_SPARE]);
        $display("three idle mixes plus a path that fills the buffer and overflows");
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #100_000_000;
        $display("timeout at %0t, %0d results still outstanding", $time, pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
sv/pdsn_pkg.sv
sv/pdsn_ram.sv
sv/path_dot_segment_normalizer.sv
sim/pdsn_checker.sv
sim/tb.sv
